// ----- rtl/core/hex_dump_line_formatter_top_defines.svh -----
// ----------------------------------------------------------------------------
// hex dump line formatter assertion macros
// shared by the checker; each macro expands to one labeled concurrent assertion
// ----------------------------------------------------------------------------
`ifndef HEX_DUMP_LINE_FORMATTER_TOP_DEFINES_SVH
`define HEX_DUMP_LINE_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HDLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define HDLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hdlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlf_pkg
// types, character codes and helper functions of the hex dump line formatter
// ----------------------------------------------------------------------------
package hdlf_pkg;

  // line geometry
  localparam int BYTES_PER_LINE = 16;
  localparam int IDX_W          = $clog2(BYTES_PER_LINE);
  localparam int CNT_W          = IDX_W + 1;
  localparam int HALF_LINE      = BYTES_PER_LINE / 2;
  localparam int OFS_W          = 32;
  localparam int OFS_DIGITS     = OFS_W / 4;

  // output word packing
  localparam int GROUP_CHARS = 8;
  localparam int GROUP_W     = GROUP_CHARS * 8;
  localparam int CCNT_W      = 4;
  localparam int ACC_CHARS   = 2 * GROUP_CHARS;
  localparam int ACC_W       = ACC_CHARS * 8;
  localparam int ACC_CNT_W   = $clog2(ACC_CHARS + 1);

  // queue depths
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);
  localparam int OUTQ_DEPTH  = 2;
  localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

  // input kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_M       = 8'h6d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7e;
  localparam logic [7:0] WS_LO      = 8'h0a;
  localparam logic [7:0] WS_HI      = 8'h0d;

  // color class codes
  localparam logic [7:0] CLS_NULL  = 8'h37;
  localparam logic [7:0] CLS_SPACE = 8'h92;
  localparam logic [7:0] CLS_PRINT = 8'h96;
  localparam logic [7:0] CLS_CTRL  = 8'h95;
  localparam logic [7:0] CLS_HIGH  = 8'h93;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [GROUP_W-1:0] chars;
    logic [CCNT_W-1:0]  char_count;
    logic               line_done;
    logic               stream_done;
  } out_word_t;

  // one complete line handed from front to back
  typedef struct packed {
    logic [BYTES_PER_LINE-1:0][7:0] line_bytes;
    logic [CNT_W-1:0]               count;
    logic                           final_line;
    logic [OFS_W-1:0]               offset;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  // formatter phases of one line
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_OFS,
    PH_GAP,
    PH_HEX,
    PH_MID,
    PH_SEP,
    PH_ASC,
    PH_END,
    PH_FLUSH
  } phase_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] class_code(input logic [7:0] b);
    if (b == 8'h00) begin
      return CLS_NULL;
    end
    if (b[7]) begin
      return CLS_HIGH;
    end
    if (b == CH_SPACE || (b >= WS_LO && b <= WS_HI)) begin
      return CLS_SPACE;
    end
    if (b > PRINT_LO && b <= PRINT_HI) begin
      return CLS_PRINT;
    end
    return CLS_CTRL;
  endfunction

  function automatic logic [7:0] shown(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) ? b : CH_DOT;
  endfunction

endpackage

// ----- rtl/core/hdlf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlf_front
// collects input bytes into a line buffer and hands finished lines to the back
// ----------------------------------------------------------------------------
module hdlf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  hdlf_pkg::in_word_t   in_data,
  input  hdlf_pkg::jobq_stat_t jq_stat,
  output logic                 jq_push,
  output hdlf_pkg::job_t       jq_wdata
);

  logic [hdlf_pkg::IDX_W-1:0] fill_r, fill_nxt;
  logic [hdlf_pkg::OFS_W-1:0] offset_r, offset_nxt;
  logic [7:0]                 line_r [hdlf_pkg::BYTES_PER_LINE];
  logic                       accept;
  logic                       is_end;
  logic                       line_full;

  // handshake and classification
  assign in_full   = jq_stat.full;
  assign accept    = in_push && !in_full;
  assign is_end    = (in_data.kind == hdlf_pkg::KIND_END);
  assign line_full = (fill_r == hdlf_pkg::IDX_W'(hdlf_pkg::BYTES_PER_LINE - 1));
  assign jq_push   = accept && (is_end || line_full);

  // line job, with the arriving byte merged into its slot
  always_comb begin
    for (int k = 0; k < hdlf_pkg::BYTES_PER_LINE; k++) begin
      jq_wdata.line_bytes[k] = (!is_end && fill_r == hdlf_pkg::IDX_W'(k)) ?
                               in_data.data_byte : line_r[k];
    end
    jq_wdata.count      = is_end ? {1'b0, fill_r} :
                          hdlf_pkg::CNT_W'(hdlf_pkg::BYTES_PER_LINE);
    jq_wdata.final_line = is_end;
    jq_wdata.offset     = offset_r;
  end

  // fill count and line offset
  always_comb begin
    fill_nxt   = fill_r;
    offset_nxt = offset_r;
    if (accept) begin
      if (is_end) begin
        fill_nxt   = '0;
        offset_nxt = '0;
      end else if (line_full) begin
        fill_nxt   = '0;
        offset_nxt = offset_r + hdlf_pkg::OFS_W'(hdlf_pkg::BYTES_PER_LINE);
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      offset_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      offset_r <= offset_nxt;
    end
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (accept && !is_end) begin
      line_r[fill_r] <= in_data.data_byte;
    end
  end

endmodule

// ----- rtl/core/hdlf_jobq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlf_jobq
// short queue of complete lines between the front and the back
// ----------------------------------------------------------------------------
module hdlf_jobq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hdlf_pkg::job_t       wdata,
  input  logic                 pop,
  output hdlf_pkg::job_t       rdata,
  output hdlf_pkg::jobq_stat_t stat
);

  hdlf_pkg::job_t                  mem_r [hdlf_pkg::JOBQ_DEPTH];
  logic [hdlf_pkg::JOBQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [hdlf_pkg::JOBQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == hdlf_pkg::JOBQ_CNT_W'(hdlf_pkg::JOBQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/hdlf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlf_back
// walks a line cell by cell, packs the text into words of up to eight characters
// ----------------------------------------------------------------------------
module hdlf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 color_enable,
  input  hdlf_pkg::jobq_stat_t jq_stat,
  output logic                 jq_pop,
  input  hdlf_pkg::job_t       jq_rdata,
  output logic                 out_empty,
  input  logic                 out_pop,
  output hdlf_pkg::out_word_t  out_data
);

  hdlf_pkg::phase_t               state_r, state_nxt;
  logic [hdlf_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  hdlf_pkg::job_t                 job_r;
  logic                           color_r;
  logic [hdlf_pkg::ACC_W-1:0]     acc_r, acc_nxt, acc_shift;
  logic [hdlf_pkg::ACC_CNT_W-1:0] fill_r, fill_nxt, emit_n, rem;

  // current segment
  logic [hdlf_pkg::GROUP_W-1:0]   seg_chars;
  logic [hdlf_pkg::CCNT_W-1:0]    seg_len;
  logic                           seg_valid;
  logic                           seg_take;

  // cell data
  logic [7:0] cur_byte;
  logic [7:0] code;
  logic [7:0] esc_c1, esc_c2, hex_hi, hex_lo, asc_ch;
  logic       blank;

  // packer
  logic                           seg_done, has_group, can_emit, emit, emit_last;
  hdlf_pkg::out_word_t            emit_word;

  // output queue
  hdlf_pkg::out_word_t            oq_r [hdlf_pkg::OUTQ_DEPTH];
  logic [hdlf_pkg::OUTQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [hdlf_pkg::OUTQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic                           oq_full, oq_pop;

  // cell fields of the byte under the index
  always_comb begin
    cur_byte = job_r.line_bytes[idx_r];
    blank    = ({1'b0, idx_r} >= job_r.count);
    code     = hdlf_pkg::class_code(cur_byte);
    esc_c1   = blank ? hdlf_pkg::CH_ZERO : hdlf_pkg::hex_char(code[7:4]);
    esc_c2   = blank ? hdlf_pkg::CH_ZERO : hdlf_pkg::hex_char(code[3:0]);
    hex_hi   = blank ? hdlf_pkg::CH_SPACE : hdlf_pkg::hex_char(cur_byte[7:4]);
    hex_lo   = blank ? hdlf_pkg::CH_SPACE : hdlf_pkg::hex_char(cur_byte[3:0]);
    asc_ch   = blank ? hdlf_pkg::CH_SPACE : hdlf_pkg::shown(cur_byte);
  end

  // fsm outputs: segment text for the current phase, line fetch
  always_comb begin
    seg_chars = '0;
    seg_len   = '0;
    seg_valid = 1'b0;
    jq_pop    = 1'b0;
    case (state_r)
      hdlf_pkg::PH_IDLE: begin
        jq_pop = !jq_stat.empty;
      end
      hdlf_pkg::PH_OFS: begin
        for (int k = 0; k < hdlf_pkg::OFS_DIGITS; k++) begin
          seg_chars[8*k +: 8] =
            hdlf_pkg::hex_char(job_r.offset[hdlf_pkg::OFS_W-1-4*k -: 4]);
        end
        seg_len   = hdlf_pkg::CCNT_W'(hdlf_pkg::OFS_DIGITS);
        seg_valid = 1'b1;
      end
      hdlf_pkg::PH_GAP: begin
        seg_chars[15:0] = {hdlf_pkg::CH_SPACE, hdlf_pkg::CH_SPACE};
        seg_len         = 4'd2;
        seg_valid       = 1'b1;
      end
      hdlf_pkg::PH_MID, hdlf_pkg::PH_SEP: begin
        seg_chars[7:0] = hdlf_pkg::CH_SPACE;
        seg_len        = 4'd1;
        seg_valid      = 1'b1;
      end
      hdlf_pkg::PH_HEX: begin
        seg_valid = 1'b1;
        if (color_r) begin
          seg_chars = {hdlf_pkg::CH_SPACE, hex_lo, hex_hi, hdlf_pkg::CH_M,
                       esc_c2, esc_c1, hdlf_pkg::CH_LBRACK, hdlf_pkg::CH_ESC};
          seg_len   = 4'd8;
        end else begin
          seg_chars[23:0] = {hdlf_pkg::CH_SPACE, hex_lo, hex_hi};
          seg_len         = 4'd3;
        end
      end
      hdlf_pkg::PH_ASC: begin
        seg_valid = 1'b1;
        if (color_r) begin
          seg_chars[47:0] = {asc_ch, hdlf_pkg::CH_M, esc_c2, esc_c1,
                             hdlf_pkg::CH_LBRACK, hdlf_pkg::CH_ESC};
          seg_len         = 4'd6;
        end else begin
          seg_chars[7:0] = asc_ch;
          seg_len        = 4'd1;
        end
      end
      hdlf_pkg::PH_END: begin
        seg_valid = 1'b1;
        if (color_r) begin
          seg_chars[39:0] = {hdlf_pkg::CH_NL, hdlf_pkg::CH_M, hdlf_pkg::CH_ZERO,
                             hdlf_pkg::CH_LBRACK, hdlf_pkg::CH_ESC};
          seg_len         = 4'd5;
        end else begin
          seg_chars[7:0] = hdlf_pkg::CH_NL;
          seg_len        = 4'd1;
        end
      end
      default: begin
        seg_valid = 1'b0;
      end
    endcase
  end

  // fsm next state and cell index
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      hdlf_pkg::PH_IDLE: begin
        if (!jq_stat.empty) begin
          state_nxt = hdlf_pkg::PH_OFS;
          idx_nxt   = '0;
        end
      end
      hdlf_pkg::PH_OFS: begin
        if (seg_take) state_nxt = hdlf_pkg::PH_GAP;
      end
      hdlf_pkg::PH_GAP: begin
        if (seg_take) begin
          state_nxt = hdlf_pkg::PH_HEX;
          idx_nxt   = '0;
        end
      end
      hdlf_pkg::PH_HEX: begin
        if (seg_take) begin
          if (idx_r == hdlf_pkg::IDX_W'(hdlf_pkg::BYTES_PER_LINE - 1)) begin
            state_nxt = hdlf_pkg::PH_SEP;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
            if (idx_r == hdlf_pkg::IDX_W'(hdlf_pkg::HALF_LINE - 1)) begin
              state_nxt = hdlf_pkg::PH_MID;
            end
          end
        end
      end
      hdlf_pkg::PH_MID: begin
        if (seg_take) state_nxt = hdlf_pkg::PH_HEX;
      end
      hdlf_pkg::PH_SEP: begin
        if (seg_take) state_nxt = hdlf_pkg::PH_ASC;
      end
      hdlf_pkg::PH_ASC: begin
        if (seg_take) begin
          if (idx_r == hdlf_pkg::IDX_W'(hdlf_pkg::BYTES_PER_LINE - 1)) begin
            state_nxt = hdlf_pkg::PH_END;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      hdlf_pkg::PH_END: begin
        if (seg_take) state_nxt = hdlf_pkg::PH_FLUSH;
      end
      hdlf_pkg::PH_FLUSH: begin
        if (emit && emit_last) state_nxt = hdlf_pkg::PH_IDLE;
      end
      default: begin
        state_nxt = hdlf_pkg::PH_IDLE;
      end
    endcase
  end

  // packer: emit a word from the bottom, append the segment above what is left
  always_comb begin
    seg_done  = (state_r == hdlf_pkg::PH_FLUSH);
    has_group = (fill_r >= hdlf_pkg::ACC_CNT_W'(hdlf_pkg::GROUP_CHARS));
    emit_last = seg_done && (fill_r <= hdlf_pkg::ACC_CNT_W'(hdlf_pkg::GROUP_CHARS));
    can_emit  = has_group || (seg_done && fill_r != '0);
    emit      = can_emit && !oq_full;
    emit_n    = has_group ? hdlf_pkg::ACC_CNT_W'(hdlf_pkg::GROUP_CHARS) : fill_r;
    rem       = emit ? (fill_r - emit_n) : fill_r;
    acc_shift = emit ? (acc_r >> hdlf_pkg::GROUP_W) : acc_r;
    seg_take  = seg_valid &&
                (({1'b0, rem} + (hdlf_pkg::ACC_CNT_W + 1)'(seg_len)) <=
                 (hdlf_pkg::ACC_CNT_W + 1)'(hdlf_pkg::ACC_CHARS));
    acc_nxt   = acc_shift;
    fill_nxt  = rem;
    if (seg_take) begin
      acc_nxt  = acc_shift |
                 ({{(hdlf_pkg::ACC_W - hdlf_pkg::GROUP_W){1'b0}}, seg_chars} <<
                  {rem, 3'b000});
      fill_nxt = rem + hdlf_pkg::ACC_CNT_W'(seg_len);
    end
    emit_word.chars       = acc_r[hdlf_pkg::GROUP_W-1:0];
    emit_word.char_count  = emit_n[hdlf_pkg::CCNT_W-1:0];
    emit_word.line_done   = emit_last;
    emit_word.stream_done = emit_last && job_r.final_line;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdlf_pkg::PH_IDLE;
      idx_r   <= '0;
      acc_r   <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // line fetch, color mode taken at line start
  always_ff @(posedge clk) begin
    if (jq_pop) begin
      job_r   <= jq_rdata;
      color_r <= color_enable;
    end
  end

  // output queue
  assign oq_full   = (oq_cnt_r == hdlf_pkg::OUTQ_CNT_W'(hdlf_pkg::OUTQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_r[oq_rd_r];

  always_comb begin
    case ({emit, oq_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 1'b1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 1'b1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (emit) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[oq_wr_r] <= emit_word;
    end
  end

endmodule

// ----- rtl/core/hex_dump_line_formatter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_dump_line_formatter_top
// Bytes in, hex dump text out: 16 bytes per line, an 8-digit offset, two hex
// halves and an ASCII column, with optional ANSI color escapes per cell. Text
// leaves as words of up to eight characters. The front takes one byte per
// cycle into its line buffer while in_full is low; a finished line goes into
// a two-line queue, so input stalls only when two lines wait behind the one
// being formatted. The back formats one cell per cycle (offset, gap, 16 hex
// cells, middle space, separator, 16 ASCII cells, line end) while its packer
// has room for the cell text. An end word flushes the pending bytes as a
// final line with blank slots, flagged by stream_done, and restarts the
// offset. color_enable is taken when the back starts a line.
// ----------------------------------------------------------------------------
module hex_dump_line_formatter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  hdlf_pkg::in_word_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output hdlf_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  logic                 color_r;
  logic                 jq_push, jq_pop;
  hdlf_pkg::job_t       jq_wdata, jq_rdata;
  hdlf_pkg::jobq_stat_t jq_stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= 1'b1;
    end else if (cfg_we) begin
      color_r <= cfg_wdata;
    end
  end

  // byte collection
  hdlf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .jq_stat  (jq_stat),
    .jq_push  (jq_push),
    .jq_wdata (jq_wdata)
  );

  // line queue
  hdlf_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (jq_wdata),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .stat  (jq_stat)
  );

  // line formatting
  hdlf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .color_enable (color_r),
    .jq_stat      (jq_stat),
    .jq_pop       (jq_pop),
    .jq_rdata     (jq_rdata),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data     (out_data)
  );

endmodule

// ----- rtl/core/hdlf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlf_checker
// port-level checks on the result words of the hex dump line formatter
// ----------------------------------------------------------------------------
`include "hex_dump_line_formatter_top_defines.svh"

module hdlf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input hdlf_pkg::out_word_t out_data
);

  // every word carries one to eight characters
  `HDLF_ASSERT_IMP(a_count_range, !out_empty, (out_data.char_count != 4'd0) && (out_data.char_count <= 4'd8), "char_count outside one to eight")

  // only the last word of a line may be short
  `HDLF_ASSERT_IMP(a_short_is_last, !out_empty && !out_data.line_done, out_data.char_count == 4'd8, "short word before end of line")

  // stream end only on a line end
  `HDLF_ASSERT_IMP(a_stream_on_line, !out_empty && out_data.stream_done, out_data.line_done, "stream_done without line_done")

  // a waiting word holds until taken
  `HDLF_ASSERT_NXT(a_hold_word, !out_empty && !out_pop, !out_empty && $stable(out_data), "waiting word changed")

endmodule

bind hex_dump_line_formatter_top hdlf_checker u_hdlf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
